>>> hdl/gbra_pkg.sv
`timescale 1ns / 1ps

package gbra_pkg;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;

	localparam logic [CFG_IW-1:0] REG_INLINE_START    = 3'd0;
	localparam logic [CFG_IW-1:0] REG_CROSSLINE_START = 3'd1;
	localparam logic [CFG_IW-1:0] REG_INLINE_STEP     = 3'd2;
	localparam logic [CFG_IW-1:0] REG_CROSSLINE_STEP  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_ROWS_IN_USE     = 3'd4;
	localparam logic [CFG_IW-1:0] REG_COLS_IN_USE     = 3'd5;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// divider: dividend 49b (48b magnitude), divisor 17b (up to 65536)
	localparam int DVD_W = 49;
	localparam int DVS_W = 17;
	localparam int CNT_W = 6;
	localparam int IX_W  = 18;

	localparam logic [CNT_W-1:0] ITER_IDX  = 6'd18;
	localparam logic [CNT_W-1:0] ITER_MEAN = 6'd49;

	localparam int WORD_W = 48;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
		logic [CNT_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> hdl/gbra_div.sv
`timescale 1ns / 1ps

module gbra_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gbra_pkg::div_req_t req,
	output gbra_pkg::div_rsp_t rsp
);
	import gbra_pkg::*;

	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			quo_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> hdl/gbra_mem.sv
`timescale 1ns / 1ps

module gbra_mem #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [gbra_pkg::WORD_W-1:0] wdata,
	input  logic [AW-1:0]               raddr,
	output logic [gbra_pkg::WORD_W-1:0] rdata
);
	import gbra_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/grid_binning_running_average_core.sv
`timescale 1ns / 1ps
// channel | dir | handshake           | word
// in      | in  | in_valid/in_stall   | operation, inline_no, crossline_no, z_value, read_row, read_col
// out     | out | out_valid/out_stall | accepted, cell_defined, mean_value, point_count
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
// Add: the word passes two index divides (inline, crossline) in the shared restoring divider,
// then, for a cell in range, the memory read, a mean divide (not for a first point) and the write.
// Read: the result word comes from the registered cell memory read.
// The core returns to idle after each item and takes no new word before the last one is through.
// After reset a clearing pass over all MAX_ROWS*MAX_COLS cells zeroes the grid; in_stall is high.
// in_stall is high while an item is in work; the next item is taken while a result waits.

module grid_binning_running_average_core #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        operation,
	input  logic [15:0]                 inline_no,
	input  logic [15:0]                 crossline_no,
	input  logic signed [31:0]          z_value,
	input  logic [7:0]                  read_row,
	input  logic [7:0]                  read_col,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        accepted,
	output logic                        cell_defined,
	output logic signed [31:0]          mean_value,
	output logic [15:0]                 point_count,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [gbra_pkg::CFG_IW-1:0] cfg_index,
	input  logic [gbra_pkg::CFG_DW-1:0] cfg_data
);
	import gbra_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int CW    = $clog2(MAX_COLS + 1);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_STI  = 4'd2;
	localparam logic [3:0] S_WTI  = 4'd3;
	localparam logic [3:0] S_STC  = 4'd4;
	localparam logic [3:0] S_WTC  = 4'd5;
	localparam logic [3:0] S_CHK  = 4'd6;
	localparam logic [3:0] S_RD   = 4'd7;
	localparam logic [3:0] S_UPD  = 4'd8;
	localparam logic [3:0] S_MUL  = 4'd9;
	localparam logic [3:0] S_STM  = 4'd10;
	localparam logic [3:0] S_WTM  = 4'd11;
	localparam logic [3:0] S_WR   = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	logic [3:0]  state_q;
	logic [15:0] il_start_q, xl_start_q;
	logic [10:0] il_step_q, xl_step_q;
	logic [8:0]  rows_q, cols_q;

	logic              op_q;
	logic [15:0]       il_q, xl_q;
	logic signed [31:0] z_q;
	logic [7:0]        rr_q, rc_q;
	logic [IX_W-1:0]   qi_q, qc_q;
	logic              ni_q, nc_q;
	logic [AW-1:0]     addr_q, clr_q;
	logic signed [DVD_W-1:0] prod_q;
	logic              mneg_q;
	logic [15:0]       n_q;
	logic signed [31:0] new_mean_q;
	logic [15:0]       new_cnt_q;
	logic              res_acc_q, res_def_q;
	logic signed [31:0] res_mean_q;
	logic [15:0]       res_cnt_q;
	logic              out_valid_q, acc_out_q, def_out_q;
	logic signed [31:0] mean_out_q;
	logic [15:0]       cnt_out_q;

	div_req_t          dreq;
	div_rsp_t          drsp;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata, mem_rdata;

	logic [RW-1:0]     rows_eff;
	logic [CW-1:0]     cols_eff;
	logic [16:0]       d_pos, d_mag;
	logic [15:0]       pos_sel, start_sel;
	logic [10:0]       step_raw, step_eff;
	logic [IX_W-1:0]   r_sel, c_sel;
	logic              in_range;
	logic signed [DVD_W-1:0] num;
	logic [DVD_W-1:0]  num_mag;
	logic [31:0]       q32;
	logic              is_idx_i;

	assign rows_eff = (32'(rows_q) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_q);
	assign cols_eff = (32'(cols_q) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_q);

	// index divide: round(|d|/s) = (2|d| + s) / 2s
	assign is_idx_i  = (state_q == S_STI);
	assign pos_sel   = is_idx_i ? il_q : xl_q;
	assign start_sel = is_idx_i ? il_start_q : xl_start_q;
	assign step_raw  = is_idx_i ? il_step_q : xl_step_q;
	assign step_eff  = (step_raw == '0) ? 11'd1 : step_raw;
	assign d_pos     = {1'b0, pos_sel} - {1'b0, start_sel};
	assign d_mag     = d_pos[16] ? 17'(-d_pos) : d_pos;

	assign num     = prod_q + DVD_W'(z_q);
	assign num_mag = num[DVD_W-1] ? DVD_W'(-num) : DVD_W'(num);
	assign q32     = drsp.quotient[31:0];

	always_comb begin
		dreq = '0;
		unique case (state_q)
			S_STI, S_STC: begin
				dreq.start    = 1'b1;
				dreq.dividend = {IX_W'({d_mag, 1'b0}) + IX_W'(step_eff),
					(DVD_W-IX_W)'(0)};
				dreq.divisor  = DVS_W'({step_eff, 1'b0});
				dreq.iters    = ITER_IDX;
			end
			S_STM: begin
				dreq.start    = 1'b1;
				dreq.dividend = num_mag;
				dreq.divisor  = DVS_W'({1'b0, n_q}) + DVS_W'(1);
				dreq.iters    = ITER_MEAN;
			end
			default: begin
				dreq = '0;
			end
		endcase
	end

	always_comb begin
		if (op_q == OP_READ) begin
			r_sel    = IX_W'(rr_q);
			c_sel    = IX_W'(rc_q);
			in_range = (r_sel < IX_W'(rows_eff)) && (c_sel < IX_W'(cols_eff));
		end else begin
			r_sel    = qi_q;
			c_sel    = qc_q;
			in_range = (!ni_q || qi_q == '0) && (!nc_q || qc_q == '0)
				&& (qi_q < IX_W'(rows_eff)) && (qc_q < IX_W'(cols_eff));
		end
	end

	always_comb begin
		if (state_q == S_CLR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = (state_q == S_WR);
			mem_waddr = addr_q;
			mem_wdata = {new_cnt_q, new_mean_q};
		end
	end

	gbra_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	gbra_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			il_start_q <= '0;
			xl_start_q <= '0;
			il_step_q  <= 11'd1;
			xl_step_q  <= 11'd1;
			rows_q     <= 9'd256;
			cols_q     <= 9'd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INLINE_START:    il_start_q <= cfg_data;
				REG_CROSSLINE_START: xl_start_q <= cfg_data;
				REG_INLINE_STEP:     il_step_q  <= cfg_data[10:0];
				REG_CROSSLINE_STEP:  xl_step_q  <= cfg_data[10:0];
				REG_ROWS_IN_USE:     rows_q     <= cfg_data[8:0];
				REG_COLS_IN_USE:     cols_q     <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (operation == OP_READ) ? S_CHK : S_STI;
					end
				end
				S_STI:  state_q <= S_WTI;
				S_WTI:  if (drsp.done) state_q <= S_STC;
				S_STC:  state_q <= S_WTC;
				S_WTC:  if (drsp.done) state_q <= S_CHK;
				S_CHK:  state_q <= in_range ? S_RD : S_DONE;
				S_RD:   state_q <= S_UPD;
				S_UPD: begin
					if (op_q == OP_READ) begin
						state_q <= S_DONE;
					end else if (mem_rdata[47:32] == '0) begin
						state_q <= S_WR;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL:  state_q <= S_STM;
				S_STM:  state_q <= S_WTM;
				S_WTM:  if (drsp.done) state_q <= S_WR;
				S_WR:   state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q <= operation;
				il_q <= inline_no;
				xl_q <= crossline_no;
				z_q  <= z_value;
				rr_q <= read_row;
				rc_q <= read_col;
			end
			S_STI: ni_q <= d_pos[16];
			S_STC: nc_q <= d_pos[16];
			S_WTI: qi_q <= drsp.quotient[IX_W-1:0];
			S_WTC: qc_q <= drsp.quotient[IX_W-1:0];
			S_CHK: begin
				addr_q     <= AW'(32'(r_sel) * 32'(MAX_COLS) + 32'(c_sel));
				res_acc_q  <= 1'b0;
				res_def_q  <= 1'b0;
				res_mean_q <= '0;
				res_cnt_q  <= '0;
			end
			S_UPD: begin
				n_q <= mem_rdata[47:32];
				if (op_q == OP_READ) begin
					if (mem_rdata[47:32] != '0) begin
						res_def_q  <= 1'b1;
						res_mean_q <= mem_rdata[31:0];
						res_cnt_q  <= mem_rdata[47:32];
					end
				end else begin
					new_mean_q <= z_q;
					new_cnt_q  <= 16'd1;
				end
				prod_q <= DVD_W'($signed({1'b0, mem_rdata[47:32]})
					* $signed(mem_rdata[31:0]));
			end
			S_STM: mneg_q <= num[DVD_W-1];
			S_WTM: begin
				new_mean_q <= mneg_q ? -q32 : q32;
				new_cnt_q  <= (n_q == 16'hFFFF) ? n_q : n_q + 16'd1;
			end
			S_WR: begin
				res_acc_q  <= 1'b1;
				res_def_q  <= 1'b1;
				res_mean_q <= new_mean_q;
				res_cnt_q  <= new_cnt_q;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					acc_out_q  <= res_acc_q;
					def_out_q  <= res_def_q;
					mean_out_q <= res_mean_q;
					cnt_out_q  <= res_cnt_q;
				end
			end
			default: ;
		endcase
	end

	assign in_stall     = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign accepted     = acc_out_q;
	assign cell_defined = def_out_q;
	assign mean_value   = mean_out_q;
	assign point_count  = cnt_out_q;

endmodule

>>> hdl/gbra_chk.sv
`timescale 1ns / 1ps

module gbra_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        accepted,
	input logic                        cell_defined,
	input logic signed [31:0]          mean_value,
	input logic [15:0]                 point_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mean_value)
			&& $stable(point_count) && $stable(cell_defined) && $stable(accepted))
		else $error("stalled output word changed");

	a_acc_defined: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> cell_defined && point_count != 16'd0)
		else $error("accepted point without a defined cell");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cell_defined |-> mean_value == 32'sd0 && point_count == 16'd0)
		else $error("undefined cell with nonzero mean or count");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on consecutive cycles");

endmodule

bind grid_binning_running_average_core gbra_chk u_gbra_chk (.*);
